>>> rtl/mcptt_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the periodic timer table.
// Used by the cell, rate and top-level modules; depends on nothing.
package mcptt_pkg;

	localparam int SLOTS = 16;
	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

	localparam logic [1:0] ACT_TICK   = 2'd0;
	localparam logic [1:0] ACT_ADD    = 2'd1;
	localparam logic [1:0] ACT_REMOVE = 2'd2;

	localparam logic [2:0] ST_EXPIRY   = 3'd0;
	localparam logic [2:0] ST_ADDED    = 3'd1;
	localparam logic [2:0] ST_PRESENT  = 3'd2;
	localparam logic [2:0] ST_REMOVED  = 3'd3;
	localparam logic [2:0] ST_NOTFOUND = 3'd4;
	localparam logic [2:0] ST_FULL     = 3'd5;

	// ms * 18 / 1000 is taken as ms * ceil(18 * 2^30 / 1000) >> 30, exact for 16-bit ms.
	localparam int PROD_W      = 41;
	localparam int RECIP_SHIFT = 30;
	localparam logic [24:0] RECIP_18K = 25'd19327353;

	typedef struct packed {
		logic        valid;
		logic [15:0] client;
		logic [10:0] reload;
		logic [10:0] countdown;
		logic [5:0]  burst;
	} slot_t;

	typedef struct packed {
		logic [10:0] reload;
		logic [5:0]  burst;
	} rate_t;

	// Burst for periods shorter than one base tick: 1000 / (ms * 18), ms from 1 to 55.
	function automatic logic [5:0] short_burst(input logic [5:0] m);
		logic [5:0] b;
		case (m)
			6'd1: b = 6'd55;
			6'd2: b = 6'd27;
			6'd3: b = 6'd18;
			6'd4: b = 6'd13;
			6'd5: b = 6'd11;
			6'd6: b = 6'd9;
			6'd7: b = 6'd7;
			6'd8, 6'd9: b = 6'd6;
			6'd10, 6'd11: b = 6'd5;
			6'd12, 6'd13: b = 6'd4;
			6'd14, 6'd15, 6'd16, 6'd17, 6'd18: b = 6'd3;
			6'd19, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25, 6'd26, 6'd27: b = 6'd2;
			default: b = 6'd1;
		endcase
		return b;
	endfunction

endpackage

>>> rtl/mcptt_in_if.sv
`timescale 1ns / 1ps
// Request channel of the periodic timer table: valid/ready plus one command word.
// Depends on nothing.
interface mcptt_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [15:0] client_id;
	logic [15:0] period_ms;

	modport source (output valid, output action, output client_id, output period_ms,
		input ready);
	modport sink (input valid, input action, input client_id, input period_ms,
		output ready);
endinterface

>>> rtl/mcptt_out_if.sv
`timescale 1ns / 1ps
// Response channel of the periodic timer table: valid/ready plus one result word.
// Depends on nothing.
interface mcptt_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [15:0] target_client;
	logic [5:0]  message_count;
	logic        last;

	modport source (output valid, output status, output target_client,
		output message_count, output last, input ready);
	modport sink (input valid, input status, input target_client,
		input message_count, input last, output ready);
endinterface

>>> rtl/mcptt_cell.sv
`timescale 1ns / 1ps
// One timer slot of the ring: holds an entry and passes it to its neighbor on a shift.
// Depends on mcptt_pkg.
module mcptt_cell import mcptt_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  shift_en,
	input  slot_t shift_d,
	input  logic  wr_en,
	input  slot_t wr_d,
	output slot_t slot
);

	logic        valid_q;
	logic [15:0] client_q;
	logic [10:0] reload_q;
	logic [10:0] countdown_q;
	logic [5:0]  burst_q;
	slot_t       nxt;

	// A direct write only happens when the ring stands still.
	assign nxt = wr_en ? wr_d : shift_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (wr_en || shift_en) begin
			valid_q <= nxt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en || shift_en) begin
			client_q    <= nxt.client;
			reload_q    <= nxt.reload;
			countdown_q <= nxt.countdown;
			burst_q     <= nxt.burst;
		end
	end

	assign slot.valid     = valid_q;
	assign slot.client    = client_q;
	assign slot.reload    = reload_q;
	assign slot.countdown = countdown_q;
	assign slot.burst     = burst_q;

endmodule

>>> rtl/mcptt_rate.sv
`timescale 1ns / 1ps
// Reload and burst of a new timer from its period, one register stage deep.
// Depends on mcptt_pkg.
module mcptt_rate import mcptt_pkg::*; (
	input  logic        clk,
	input  logic [15:0] period_ms,
	output rate_t       rate
);

	logic [15:0]       m;
	logic [15:0]       m_s1;
	logic [PROD_W-1:0] prod_s1;
	logic [10:0]       q;

	assign m = (period_ms == 16'd0) ? 16'd1 : period_ms;

	always_ff @(posedge clk) begin
		m_s1    <= m;
		prod_s1 <= {{(PROD_W - 16){1'b0}}, m} * {{(PROD_W - 25){1'b0}}, RECIP_18K};
	end

	assign q = prod_s1[PROD_W-1:RECIP_SHIFT];

	// A zero quotient means the period is at most 55 ms, so the low six bits hold it.
	assign rate.reload = (q == 11'd0) ? 11'd1 : q;
	assign rate.burst  = (q == 11'd0) ? short_burst(m_s1[5:0]) : 6'd1;

endmodule

>>> rtl/multi_client_periodic_timer_table_top.sv
`timescale 1ns / 1ps
// Periodic timer table: a ring of slot cells walked through a head stage, one slot a cycle unless a tick waits.
// Depends on mcptt_pkg, mcptt_in_if, mcptt_out_if, mcptt_cell and mcptt_rate.
//
//  channel  dir  word
//  req      in   action, client_id, period_ms
//  rsp      out  status, target_client, message_count, last
//
// A word is taken only in the idle state after the earlier word is done, so no new word is
// taken while the ring is walked for the last one. Add and remove rotate the whole ring
// past the head, then post the status word, which waits while the response register
// stays full. A tick rotates the whole ring, then a flush state posts its final expiry;
// each expiry beyond the first can hold the ring for as long as the response register is full.
// Reset clears the valid bits of all slots and the control state; no clearing pass.
module multi_client_periodic_timer_table_top import mcptt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	mcptt_in_if.sink    req,
	mcptt_out_if.source rsp
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_LOOK   = 3'd1;
	localparam logic [2:0] S_TICK   = 3'd2;
	localparam logic [2:0] S_FLUSH  = 3'd3;
	localparam logic [2:0] S_STATUS = 3'd4;

	logic [2:0]       state_q;
	logic [IDX_W-1:0] step_q;
	logic [1:0]       act_q;
	logic [15:0]      who_q;
	logic [15:0]      ms_q;
	logic             found_q;
	logic [IDX_W-1:0] found_idx_q;
	logic             free_q;
	logic [IDX_W-1:0] free_idx_q;
	logic             pend_q;
	logic [15:0]      pend_client_q;
	logic [5:0]       pend_burst_q;

	logic             out_valid_q;
	logic [2:0]       out_status_q;
	logic [15:0]      out_client_q;
	logic [5:0]       out_count_q;
	logic             out_last_q;

	slot_t            ring [SLOTS];
	slot_t            ring_d [SLOTS];
	slot_t            head;
	slot_t            head_next;
	slot_t            wr_d;
	logic [SLOTS-1:0] wr_en_vec;
	logic [IDX_W-1:0] wr_idx;
	rate_t            rate;

	logic             out_free;
	logic [10:0]      dec;
	logic             expire;
	logic             step_go;
	logic             pass_end;
	logic             status_go;
	logic             commit;
	logic [2:0]       status_code;
	logic             push;
	logic [2:0]       push_status;
	logic [15:0]      push_client;
	logic [5:0]       push_count;
	logic             push_last;

	assign req.ready = (state_q == S_IDLE);
	assign out_free  = !out_valid_q || rsp.ready;
	assign head      = ring[0];

	// Tick work on the head slot.
	assign dec      = head.countdown - 11'd1;
	assign expire   = (state_q == S_TICK) && head.valid && (dec == 11'd0);
	assign step_go  = (state_q == S_LOOK) ||
		((state_q == S_TICK) && !(expire && pend_q && !out_free));
	assign pass_end = step_go && (step_q == LAST_IDX);

	always_comb begin
		head_next = head;
		if ((state_q == S_TICK) && head.valid) begin
			head_next.countdown = expire ? head.reload : dec;
		end
	end

	// Outcome of an add or remove once the whole ring has been searched.
	always_comb begin
		status_code = ST_NOTFOUND;
		commit      = 1'b0;
		wr_idx      = found_idx_q;
		wr_d        = '0;
		if (act_q == ACT_ADD) begin
			wr_idx         = free_idx_q;
			wr_d.valid     = 1'b1;
			wr_d.client    = who_q;
			wr_d.reload    = rate.reload;
			wr_d.countdown = rate.reload;
			wr_d.burst     = rate.burst;
			if (found_q) begin
				status_code = ST_PRESENT;
			end else if (!free_q) begin
				status_code = ST_FULL;
			end else begin
				status_code = ST_ADDED;
				commit      = status_go;
			end
		end else begin
			if (found_q) begin
				status_code = ST_REMOVED;
				commit      = status_go;
			end
		end
	end

	assign status_go = (state_q == S_STATUS) && out_free;

	// An expiry is held back until the next expiry or the flush, so the last one of a tick can be marked.
	always_comb begin
		push        = 1'b0;
		push_status = ST_EXPIRY;
		push_client = pend_client_q;
		push_count  = pend_burst_q;
		push_last   = 1'b0;
		case (state_q)
			S_TICK: begin
				push = step_go && expire && pend_q;
			end
			S_FLUSH: begin
				push      = pend_q && out_free;
				push_last = 1'b1;
			end
			S_STATUS: begin
				push        = out_free;
				push_status = status_code;
				push_client = who_q;
				push_count  = 6'd0;
				push_last   = 1'b1;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		if (i == SLOTS - 1) begin : g_tail
			assign ring_d[i] = head_next;
		end else begin : g_mid
			assign ring_d[i] = ring[i+1];
		end
		assign wr_en_vec[i] = commit && (wr_idx == IDX_W'(i));

		mcptt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (step_go),
			.shift_d  (ring_d[i]),
			.wr_en    (wr_en_vec[i]),
			.wr_d     (wr_d),
			.slot     (ring[i])
		);
	end

	mcptt_rate u_rate (
		.clk       (clk),
		.period_ms (ms_q),
		.rate      (rate)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			found_q <= 1'b0;
			free_q  <= 1'b0;
			pend_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					step_q  <= '0;
					found_q <= 1'b0;
					free_q  <= 1'b0;
					pend_q  <= 1'b0;
					if (req.valid) begin
						if (req.action == ACT_TICK) begin
							state_q <= S_TICK;
						end else if (req.action == ACT_ADD || req.action == ACT_REMOVE) begin
							state_q <= S_LOOK;
						end
					end
				end
				S_LOOK: begin
					if (head.valid && head.client == who_q) begin
						found_q <= 1'b1;
					end
					if (!head.valid && !free_q) begin
						free_q <= 1'b1;
					end
					step_q <= pass_end ? '0 : step_q + 1'b1;
					if (pass_end) begin
						state_q <= S_STATUS;
					end
				end
				S_TICK: begin
					if (step_go) begin
						if (expire) begin
							pend_q <= 1'b1;
						end
						step_q <= pass_end ? '0 : step_q + 1'b1;
						if (pass_end) begin
							state_q <= S_FLUSH;
						end
					end
				end
				S_FLUSH: begin
					if (!pend_q || out_free) begin
						pend_q  <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				S_STATUS: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			act_q <= req.action;
			who_q <= req.client_id;
			ms_q  <= req.period_ms;
		end
		if (state_q == S_LOOK) begin
			if (head.valid && head.client == who_q && !found_q) begin
				found_idx_q <= step_q;
			end
			if (!head.valid && !free_q) begin
				free_idx_q <= step_q;
			end
		end
		if (step_go && expire) begin
			pend_client_q <= head.client;
			pend_burst_q  <= head.burst;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_status_q <= push_status;
			out_client_q <= push_client;
			out_count_q  <= push_count;
			out_last_q   <= push_last;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = out_status_q;
	assign rsp.target_client = out_client_q;
	assign rsp.message_count = out_count_q;
	assign rsp.last          = out_last_q;

	// A new word never lands on a response word that has not been taken.
	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> out_free)
		else $error("response register overwritten");

	// A held expiry exists only while a tick is being worked off.
	a_pend_tick: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> (state_q == S_TICK || state_q == S_FLUSH))
		else $error("expiry pending outside a tick");

	// Slot cells are written directly only while the ring is at rest in slot order.
	a_commit_rest: assert property (@(posedge clk) disable iff (!arst_n)
		(|wr_en_vec) |-> (!step_go && $onehot(wr_en_vec) && step_q == '0))
		else $error("slot written while the ring moves");

endmodule
